@@ hdl/arfl_pkg.sv @@
// ----------------------------------------------------------------------------
// arfl_pkg
// Shared widths, request and status codes, and sequencer states for the
// aligned region free list.
// ----------------------------------------------------------------------------
package arfl_pkg;

  localparam int ACT_W = 2;
  localparam int ST_W  = 2;
  localparam int PS_W  = 31;
  localparam int PC_W  = 32;
  localparam int SZ_W  = 64;  // run length and alignment arithmetic

  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_AT    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK         = 2'd0;
  localparam logic [ST_W-1:0] ST_MISALIGNED = 2'd1;
  localparam logic [ST_W-1:0] ST_NOFIT      = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL       = 2'd3;

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_MUL   = 19'h00002,
    S_CHK   = 19'h00004,
    S_MODA  = 19'h00008,
    S_SCAN  = 19'h00010,
    S_LAT   = 19'h00020,
    S_MODW  = 19'h00040,
    S_FIT   = 19'h00080,
    S_CARVE = 19'h00100,
    S_FRD   = 19'h00200,
    S_MCHK  = 19'h00400,
    S_MLAT  = 19'h00800,
    S_SDR   = 19'h01000,
    S_SDW   = 19'h02000,
    S_SUR   = 19'h04000,
    S_SUW   = 19'h08000,
    S_WRA   = 19'h10000,
    S_WRB   = 19'h20000,
    S_OUT   = 19'h40000
  } state_e;

endpackage

@@ hdl/arfl_ram.sv @@
// ----------------------------------------------------------------------------
// arfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arfl_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/arfl_mod_unit.sv @@
// ----------------------------------------------------------------------------
// arfl_mod_unit
// Bit-serial restoring remainder unit: dividend mod page size, one dividend
// bit per cycle.
// ----------------------------------------------------------------------------
module arfl_mod_unit #(
  parameter int DW = 48
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DW-1:0]            dividend_i,
  input  logic [arfl_pkg::PS_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [arfl_pkg::PS_W-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic                      busy_q, busy_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic [DW-1:0]             dvd_q, dvd_d;
  logic [arfl_pkg::PS_W-1:0] dvs_q, dvs_d;
  logic [arfl_pkg::PS_W-1:0] rem_q, rem_d;
  logic [arfl_pkg::PS_W:0]   trial;

  assign trial  = {rem_q, dvd_q[DW-1]};
  assign done_o = busy_q && (cnt_q == '0);
  assign rem_o  = rem_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        dvd_d = {dvd_q[DW-2:0], 1'b0};
        if (trial >= {1'b0, dvs_q}) begin
          rem_d = arfl_pkg::PS_W'(trial - {1'b0, dvs_q});
        end else begin
          rem_d = arfl_pkg::PS_W'(trial);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

endmodule

@@ hdl/aligned_region_free_list_core.sv @@
// ----------------------------------------------------------------------------
// aligned_region_free_list_core
// First-fit allocator over a sorted table of free regions, with aligned
// allocate, allocate-at and merging free.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. A plain allocate visits
// regions in address order and aligns each region start with the bit-serial
// remainder unit. Allocate-at first checks its alignment with the same unit,
// then visits regions in address order, as does free. Inserting or removing
// an entry moves the entries above it one by one through the region table,
// reading each and then writing it; an insert ends with one or two entry
// writes. The table is empty after reset and needs no clearing pass.
module aligned_region_free_list_core #(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [arfl_pkg::ACT_W-1:0]        action_i,
  input  logic [ADDR_BITS-1:0]              address_i,
  input  logic [arfl_pkg::PS_W-1:0]         page_size_i,
  input  logic [arfl_pkg::PC_W-1:0]         page_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [arfl_pkg::ST_W-1:0]         status_o,
  output logic [ADDR_BITS-1:0]              result_address_o
);

  localparam int A    = ADDR_BITS;
  localparam int SW   = arfl_pkg::SZ_W;
  localparam int IW   = $clog2(MAX_REGIONS);
  localparam int CNTW = $clog2(MAX_REGIONS + 1);
  localparam logic [A-1:0] AMAX = '1;

  arfl_pkg::state_e state_q, state_d;

  logic [arfl_pkg::ACT_W-1:0] act_q, act_d;
  logic [A-1:0]               addr_q, addr_d;
  logic [arfl_pkg::PS_W-1:0]  ps_q, ps_d;
  logic [arfl_pkg::PC_W-1:0]  pc_q, pc_d;
  logic [SW-1:0]              size_q, size_d;
  logic [CNTW-1:0]            cnt_q, cnt_d, i_q, i_d, k_q, k_d;
  logic [A-1:0]               cs_q, cs_d, cl_q, cl_d, res_q, res_d;
  logic [SW-1:0]              chop_q, chop_d, rest_q, rest_d;
  logic                       le_q, le_d, w2en_q, w2en_d, retm_q, retm_d;
  logic [A-1:0]               w1s_q, w1s_d, w1l_q, w1l_d, w2s_q, w2s_d, w2l_q, w2l_d;
  logic [arfl_pkg::ST_W-1:0]  st_q, st_d;
  logic                       ov_q, ov_d;
  logic [arfl_pkg::ST_W-1:0]  ost_q, ost_d;
  logic [A-1:0]               ores_q, ores_d;

  logic [arfl_pkg::PS_W+arfl_pkg::PC_W-1:0] prod;
  logic [SW-1:0]  amax_w, space_left, tail;
  logic [A-1:0]   run_end, rd_s, rd_l;
  logic           mod_start, mod_done;
  logic [A-1:0]   mod_dvd;
  logic [arfl_pkg::PS_W-1:0] mod_rem;
  logic           we;
  logic [IW-1:0]  waddr, raddr;
  logic [2*A-1:0] wdata, rdata;
  logic           in_acc, full;

  assign prod       = ps_q * pc_q;
  assign amax_w     = SW'(AMAX);
  assign space_left = amax_w - SW'(addr_q);
  assign tail       = rest_q - size_q;
  assign run_end    = addr_q + size_q[A-1:0];
  assign rd_s       = rdata[2*A-1:A];
  assign rd_l       = rdata[A-1:0];
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CNTW'(MAX_REGIONS));

  assign in_stall_o       = (state_q != arfl_pkg::S_IDLE);
  assign out_valid_o      = ov_q;
  assign status_o         = ost_q;
  assign result_address_o = ores_q;

  arfl_mod_unit #(.DW(A)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dvd),
    .divisor_i  (ps_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  arfl_ram #(.WIDTH(2 * A), .DEPTH(MAX_REGIONS)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    act_d = act_q; addr_d = addr_q; ps_d = ps_q; pc_d = pc_q; size_d = size_q;
    cnt_d = cnt_q; i_d = i_q; k_d = k_q;
    cs_d = cs_q; cl_d = cl_q; res_d = res_q;
    chop_d = chop_q; rest_d = rest_q; le_d = le_q;
    w1s_d = w1s_q; w1l_d = w1l_q; w2s_d = w2s_q; w2l_d = w2l_q;
    w2en_d = w2en_q; retm_d = retm_q; st_d = st_q;
    ov_d = ov_q; ost_d = ost_q; ores_d = ores_q;
    mod_start = 1'b0;
    mod_dvd   = addr_q;
    we        = 1'b0;
    waddr     = i_q[IW-1:0];
    wdata     = {w1s_q, w1l_q};
    raddr     = i_q[IW-1:0];

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      arfl_pkg::S_IDLE: begin
        if (in_acc) begin
          act_d   = action_i;
          addr_d  = address_i;
          ps_d    = page_size_i;
          pc_d    = page_count_i;
          state_d = arfl_pkg::S_MUL;
        end
      end
      arfl_pkg::S_MUL: begin
        size_d  = SW'(prod);
        i_d     = '0;
        state_d = arfl_pkg::S_CHK;
      end
      arfl_pkg::S_CHK: begin
        state_d = arfl_pkg::S_OUT;
        if (act_q != arfl_pkg::ACT_ALLOC && act_q != arfl_pkg::ACT_AT &&
            act_q != arfl_pkg::ACT_FREE) begin
          st_d = arfl_pkg::ST_NOFIT;
        end else if (ps_q == '0) begin
          st_d = arfl_pkg::ST_MISALIGNED;
        end else if (act_q == arfl_pkg::ACT_FREE) begin
          if (size_q == '0) begin
            st_d = arfl_pkg::ST_OK;
          end else if (size_q > space_left) begin
            st_d = arfl_pkg::ST_NOFIT;
          end else begin
            state_d = arfl_pkg::S_SCAN;
          end
        end else if (act_q == arfl_pkg::ACT_AT) begin
          mod_start = 1'b1;
          state_d   = arfl_pkg::S_MODA;
        end else if (size_q == '0) begin
          st_d = arfl_pkg::ST_NOFIT;
        end else begin
          state_d = arfl_pkg::S_SCAN;
        end
      end
      arfl_pkg::S_MODA: begin
        if (mod_done) begin
          state_d = arfl_pkg::S_OUT;
          if (mod_rem != '0) begin
            st_d = arfl_pkg::ST_MISALIGNED;
          end else if (size_q == '0 || size_q > space_left) begin
            st_d = arfl_pkg::ST_NOFIT;
          end else begin
            state_d = arfl_pkg::S_SCAN;
          end
        end
      end
      arfl_pkg::S_SCAN: begin
        if (i_q == cnt_q) begin
          if (act_q == arfl_pkg::ACT_FREE) begin
            // no neighbor found: append at the end
            if (full) begin
              st_d    = arfl_pkg::ST_FULL;
              state_d = arfl_pkg::S_OUT;
            end else begin
              w1s_d = addr_q; w1l_d = size_q[A-1:0]; w2en_d = 1'b0;
              k_d = cnt_q; cnt_d = cnt_q + 1'b1; st_d = arfl_pkg::ST_OK;
              state_d = arfl_pkg::S_SUR;
            end
          end else begin
            st_d    = arfl_pkg::ST_NOFIT;
            state_d = arfl_pkg::S_OUT;
          end
        end else begin
          state_d = arfl_pkg::S_LAT;
        end
      end
      arfl_pkg::S_LAT: begin
        cs_d = rd_s;
        cl_d = rd_l;
        if (act_q == arfl_pkg::ACT_FREE) begin
          state_d = arfl_pkg::S_FRD;
        end else if (act_q == arfl_pkg::ACT_AT) begin
          chop_d  = SW'(addr_q - rd_s);
          le_d    = (rd_s <= addr_q);
          state_d = arfl_pkg::S_FIT;
        end else begin
          mod_dvd   = rd_s;
          mod_start = 1'b1;
          state_d   = arfl_pkg::S_MODW;
        end
      end
      arfl_pkg::S_MODW: begin
        if (mod_done) begin
          chop_d  = (mod_rem == '0) ? '0 : SW'(ps_q) - SW'(mod_rem);
          le_d    = 1'b1;
          state_d = arfl_pkg::S_FIT;
        end
      end
      arfl_pkg::S_FIT: begin
        rest_d = SW'(cl_q) - chop_q;
        res_d  = cs_q + chop_q[A-1:0];
        if (le_q && chop_q <= SW'(cl_q) && size_q <= SW'(cl_q) - chop_q) begin
          state_d = arfl_pkg::S_CARVE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = arfl_pkg::S_SCAN;
        end
      end
      arfl_pkg::S_CARVE: begin
        st_d   = arfl_pkg::ST_OK;
        w2en_d = 1'b0;
        if (chop_q != '0 && tail != '0) begin
          if (full) begin
            st_d    = arfl_pkg::ST_FULL;
            state_d = arfl_pkg::S_OUT;
          end else begin
            // split: head stays at i, tail goes to i+1
            w1s_d = cs_q; w1l_d = chop_q[A-1:0];
            w2s_d = res_q + size_q[A-1:0]; w2l_d = tail[A-1:0]; w2en_d = 1'b1;
            k_d = cnt_q; cnt_d = cnt_q + 1'b1;
            state_d = arfl_pkg::S_SUR;
          end
        end else if (chop_q != '0) begin
          w1s_d = cs_q; w1l_d = chop_q[A-1:0];
          state_d = arfl_pkg::S_WRA;
        end else if (tail != '0) begin
          w1s_d = res_q + size_q[A-1:0]; w1l_d = tail[A-1:0];
          state_d = arfl_pkg::S_WRA;
        end else begin
          k_d = i_q; retm_d = 1'b0;
          state_d = arfl_pkg::S_SDR;
        end
      end
      arfl_pkg::S_FRD: begin
        st_d = arfl_pkg::ST_OK;
        if (cs_q == run_end) begin
          w1s_d = addr_q; w1l_d = cl_q + size_q[A-1:0]; w2en_d = 1'b0;
          state_d = arfl_pkg::S_WRA;
        end else if (cs_q + cl_q == addr_q) begin
          cl_d    = cl_q + size_q[A-1:0];
          state_d = arfl_pkg::S_MCHK;
        end else if (addr_q < cs_q) begin
          if (full) begin
            st_d    = arfl_pkg::ST_FULL;
            state_d = arfl_pkg::S_OUT;
          end else begin
            w1s_d = addr_q; w1l_d = size_q[A-1:0]; w2en_d = 1'b0;
            k_d = cnt_q; cnt_d = cnt_q + 1'b1;
            state_d = arfl_pkg::S_SUR;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = arfl_pkg::S_SCAN;
        end
      end
      arfl_pkg::S_MCHK: begin
        raddr = IW'(i_q + 1'b1);
        if (i_q + 1'b1 < cnt_q) begin
          state_d = arfl_pkg::S_MLAT;
        end else begin
          w1s_d = cs_q; w1l_d = cl_q; w2en_d = 1'b0;
          state_d = arfl_pkg::S_WRA;
        end
      end
      arfl_pkg::S_MLAT: begin
        if (cs_q + cl_q == rd_s) begin
          cl_d = cl_q + rd_l;
          k_d = i_q + 1'b1; retm_d = 1'b1;
          state_d = arfl_pkg::S_SDR;
        end else begin
          w1s_d = cs_q; w1l_d = cl_q; w2en_d = 1'b0;
          state_d = arfl_pkg::S_WRA;
        end
      end
      arfl_pkg::S_SDR: begin
        raddr = IW'(k_q + 1'b1);
        if (k_q + 1'b1 < cnt_q) begin
          state_d = arfl_pkg::S_SDW;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = retm_q ? arfl_pkg::S_MCHK : arfl_pkg::S_OUT;
        end
      end
      arfl_pkg::S_SDW: begin
        we      = 1'b1;
        waddr   = k_q[IW-1:0];
        wdata   = rdata;
        k_d     = k_q + 1'b1;
        state_d = arfl_pkg::S_SDR;
      end
      arfl_pkg::S_SUR: begin
        raddr = IW'(k_q - 1'b1);
        if (k_q == i_q) begin
          state_d = arfl_pkg::S_WRA;
        end else begin
          state_d = arfl_pkg::S_SUW;
        end
      end
      arfl_pkg::S_SUW: begin
        we      = 1'b1;
        waddr   = k_q[IW-1:0];
        wdata   = rdata;
        k_d     = k_q - 1'b1;
        state_d = arfl_pkg::S_SUR;
      end
      arfl_pkg::S_WRA: begin
        we      = 1'b1;
        state_d = w2en_q ? arfl_pkg::S_WRB : arfl_pkg::S_OUT;
      end
      arfl_pkg::S_WRB: begin
        we      = 1'b1;
        waddr   = IW'(i_q + 1'b1);
        wdata   = {w2s_q, w2l_q};
        state_d = arfl_pkg::S_OUT;
      end
      arfl_pkg::S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d  = 1'b1;
          ost_d = st_q;
          ores_d = (st_q == arfl_pkg::ST_OK && act_q != arfl_pkg::ACT_FREE) ? res_q : '0;
          state_d = arfl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = arfl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arfl_pkg::S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; addr_q <= addr_d; ps_q <= ps_d; pc_q <= pc_d; size_q <= size_d;
    i_q <= i_d; k_q <= k_d; cs_q <= cs_d; cl_q <= cl_d; res_q <= res_d;
    chop_q <= chop_d; rest_q <= rest_d; le_q <= le_d;
    w1s_q <= w1s_d; w1l_q <= w1l_d; w2s_q <= w2s_d; w2l_q <= w2l_d;
    w2en_q <= w2en_d; retm_q <= retm_d; st_q <= st_d;
    ost_q <= ost_d; ores_q <= ores_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(MAX_REGIONS))
    else $error("region count beyond table depth");

  a_wr_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CNTW'(waddr) < cnt_q))
    else $error("table write outside live entries");

  a_mod_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == arfl_pkg::S_MODA || state_q == arfl_pkg::S_MODW))
    else $error("remainder result with no waiting state");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == arfl_pkg::S_MUL))
    else $error("accepted item did not start");

endmodule

@@ verif/region_table_checker.sv @@
// ----------------------------------------------------------------------------
// region_table_checker
// Watches both channels of the free list core, keeps its own copy of the
// sorted region table, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module region_table_checker #(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [arfl_pkg::ACT_W-1:0] action_i,
  input  logic [ADDR_BITS-1:0]      address_i,
  input  logic [arfl_pkg::PS_W-1:0] page_size_i,
  input  logic [arfl_pkg::PC_W-1:0] page_count_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [arfl_pkg::ST_W-1:0] status_i,
  input  logic [ADDR_BITS-1:0]      result_address_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  localparam logic [63:0] SPACE_MASK = (64'd1 << ADDR_BITS) - 64'd1;

  typedef struct packed {
    logic [arfl_pkg::ST_W-1:0] status;
    logic [ADDR_BITS-1:0]      addr;
  } alloc_result_t;

  logic [63:0]   free_start [MAX_REGIONS];
  logic [63:0]   free_len   [MAX_REGIONS];
  int            free_cnt;
  alloc_result_t expected_results[$];
  int            fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_results.size();

  task automatic drop_region(input int idx);
    for (int k = idx; k + 1 < free_cnt; k++) begin
      free_start[k] = free_start[k+1];
      free_len[k]   = free_len[k+1];
    end
    if (free_cnt > 0) free_cnt--;
  endtask

  task automatic add_region(input int idx, input logic [63:0] s, input logic [63:0] len,
                            output bit ok);
    ok = 0;
    if (free_cnt < MAX_REGIONS && idx <= free_cnt) begin
      for (int k = free_cnt; k > idx; k--) begin
        free_start[k] = free_start[k-1];
        free_len[k]   = free_len[k-1];
      end
      free_start[idx] = s;
      free_len[idx]   = len;
      free_cnt++;
      ok = 1;
    end
  endtask

  task automatic carve_run(input int idx, input logic [63:0] chop, input logic [63:0] size,
                           output logic [arfl_pkg::ST_W-1:0] st);
    logic [63:0] s;
    logic [63:0] tail;
    bit ok;
    s    = free_start[idx];
    tail = free_len[idx] - chop - size;
    st   = arfl_pkg::ST_OK;
    if (chop != 0 && tail != 0) begin
      if (free_cnt >= MAX_REGIONS) begin
        st = arfl_pkg::ST_FULL;
      end else begin
        free_start[idx] = s + chop + size;
        free_len[idx]   = tail;
        add_region(idx, s, chop, ok);
      end
    end else if (chop != 0) begin
      free_len[idx] = chop;
    end else if (tail != 0) begin
      free_start[idx] = s + size;
      free_len[idx]   = tail;
    end else begin
      drop_region(idx);
    end
  endtask

  function automatic bit fits_space(input logic [63:0] a, input logic [63:0] size);
    return a <= SPACE_MASK && size <= SPACE_MASK - a;
  endfunction

  task automatic predict_request(input logic [arfl_pkg::ACT_W-1:0] act,
                                 input logic [63:0] a,
                                 input logic [63:0] ps, input logic [63:0] pc,
                                 output alloc_result_t r);
    logic [63:0] size;
    logic [63:0] res;
    logic [63:0] s;
    logic [63:0] len;
    logic [63:0] rem;
    logic [63:0] chop;
    logic [63:0] fin;
    logic [arfl_pkg::ST_W-1:0] st;
    bit done;
    bit ok;
    int i;
    size = ps * pc;
    res  = 0;
    st   = arfl_pkg::ST_NOFIT;
    done = 0;
    if (act != arfl_pkg::ACT_ALLOC && act != arfl_pkg::ACT_AT &&
        act != arfl_pkg::ACT_FREE) begin
      st = arfl_pkg::ST_NOFIT;
    end else if (ps == 0) begin
      st = arfl_pkg::ST_MISALIGNED;
    end else if (act == arfl_pkg::ACT_FREE) begin
      if (size == 0) begin
        st = arfl_pkg::ST_OK;
      end else if (!fits_space(a, size)) begin
        st = arfl_pkg::ST_NOFIT;
      end else begin
        fin = a + size;
        i = 0;
        while (i < free_cnt && !done) begin
          s = free_start[i];
          if (s == fin) begin
            free_start[i] = a;
            free_len[i]  += size;
            st = arfl_pkg::ST_OK;
            done = 1;
          end else if (s + free_len[i] == a) begin
            free_len[i] += size;
            // absorb following regions that now touch
            while (i + 1 < free_cnt && free_start[i] + free_len[i] == free_start[i+1]) begin
              free_len[i] += free_len[i+1];
              drop_region(i + 1);
            end
            st = arfl_pkg::ST_OK;
            done = 1;
          end else if (a < s) begin
            break;
          end else begin
            i++;
          end
        end
        if (!done) begin
          add_region(i, a, size, ok);
          st = ok ? arfl_pkg::ST_OK : arfl_pkg::ST_FULL;
        end
      end
    end else if (act == arfl_pkg::ACT_AT && (a % ps) != 0) begin
      st = arfl_pkg::ST_MISALIGNED;
    end else if (size == 0) begin
      st = arfl_pkg::ST_NOFIT;
    end else if (act == arfl_pkg::ACT_AT) begin
      if (fits_space(a, size)) begin
        for (i = 0; i < free_cnt && !done; i++) begin
          s   = free_start[i];
          len = free_len[i];
          if (s <= a && a - s <= len && size <= len - (a - s)) begin
            carve_run(i, a - s, size, st);
            res  = a;
            done = 1;
          end
        end
      end
    end else begin
      for (i = 0; i < free_cnt && !done; i++) begin
        s    = free_start[i];
        len  = free_len[i];
        rem  = s % ps;
        chop = (rem != 0) ? ps - rem : 64'd0;
        if (chop <= len && size <= len - chop) begin
          carve_run(i, chop, size, st);
          res  = s + chop;
          done = 1;
        end
      end
    end
    if (st != arfl_pkg::ST_OK) res = 0;
    r.status = st;
    r.addr   = res[ADDR_BITS-1:0];
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t r;
    if (!rst_ni) begin
      free_cnt = 0;
      fails    = 0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_request(action_i, 64'(address_i), 64'(page_size_i), 64'(page_count_i), r);
        expected_results.push_back(r);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", 64'(status_i), 64'd0);
        end else begin
          r = expected_results.pop_front();
          if (status_i != r.status)
            report_mismatch("status", 64'(status_i), 64'(r.status));
          if (result_address_i != r.addr)
            report_mismatch("result_address", 64'(result_address_i), 64'(r.addr));
        end
      end
    end
  end

endmodule

@@ verif/aligned_region_free_list_core_test.sv @@
// ----------------------------------------------------------------------------
// aligned_region_free_list_core_test
// Drives directed and random allocate, allocate-at, free and invalid requests with
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module aligned_region_free_list_core_test;

  localparam int MAX_REGIONS = 16;
  localparam int ADDR_BITS   = 48;
  localparam logic [arfl_pkg::ACT_W-1:0] ACT_BAD = 2'd3;
  localparam int RANDOM_ITEMS = 800;
  localparam int CALM_ITEMS   = 100;
  localparam int IDLE_LIMIT   = 20000;
  localparam logic [ADDR_BITS-1:0] POOL_BASE = 48'h0000_4000_0000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic [arfl_pkg::ACT_W-1:0] action_i = arfl_pkg::ACT_ALLOC;
  logic [ADDR_BITS-1:0] address_i = '0;
  logic [arfl_pkg::PS_W-1:0] page_size_i = '0;
  logic [arfl_pkg::PC_W-1:0] page_count_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [arfl_pkg::ST_W-1:0] status_o;
  logic [ADDR_BITS-1:0] result_address_o;

  int fail_count;
  int pending;
  int items_sent = 0;
  bit calm = 0;
  bit hold_req = 0;
  int idle_cycles = 0;

  aligned_region_free_list_core #(.MAX_REGIONS(MAX_REGIONS), .ADDR_BITS(ADDR_BITS)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .address_i, .page_size_i,
    .page_count_i, .out_valid_o, .out_stall_i, .status_o, .result_address_o
  );

  region_table_checker #(.MAX_REGIONS(MAX_REGIONS), .ADDR_BITS(ADDR_BITS)) checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .address_i,
    .page_size_i, .page_count_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .result_address_i(result_address_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_item(input logic [arfl_pkg::ACT_W-1:0] act,
                           input logic [ADDR_BITS-1:0] a,
                           input logic [arfl_pkg::PS_W-1:0] ps,
                           input logic [arfl_pkg::PC_W-1:0] pc);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i   <= 1;
    action_i     <= act;
    address_i    <= a;
    page_size_i  <= ps;
    page_count_i <= pc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Mostly requests inside a small pool so regions merge, split and fill up.
  task automatic send_random;
    int kind;
    logic [arfl_pkg::PS_W-1:0] ps;
    logic [ADDR_BITS-1:0] a;
    kind = $urandom_range(0, 99);
    ps = arfl_pkg::PS_W'(1) << $urandom_range(0, 13);
    if ($urandom_range(0, 9) == 0) ps = arfl_pkg::PS_W'($urandom_range(1, 5000));
    if (kind < 10) begin
      send_item(arfl_pkg::ACT_W'($urandom), ADDR_BITS'({$urandom, $urandom}),
                arfl_pkg::PS_W'($urandom),
                ($urandom_range(0, 1) ? arfl_pkg::PC_W'($urandom_range(0, 4))
                                      : arfl_pkg::PC_W'($urandom)));
    end else if (kind < 55) begin
      a = POOL_BASE + ADDR_BITS'($urandom_range(0, 63)) * 48'd4096;
      send_item(arfl_pkg::ACT_FREE, a, 31'd4096, arfl_pkg::PC_W'($urandom_range(1, 8)));
    end else if (kind < 85) begin
      send_item(arfl_pkg::ACT_ALLOC, ADDR_BITS'({$urandom, $urandom}), ps,
                arfl_pkg::PC_W'($urandom_range(1, 6)));
    end else begin
      a = POOL_BASE + ADDR_BITS'($urandom_range(0, 255)) * ADDR_BITS'(ps);
      if ($urandom_range(0, 7) == 0) a = a + ADDR_BITS'(1);
      send_item(arfl_pkg::ACT_AT, a, ps, arfl_pkg::PC_W'($urandom_range(1, 6)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_item(arfl_pkg::ACT_ALLOC, '0, 31'd4096, 32'd1);             // empty table
    send_item(arfl_pkg::ACT_FREE, 48'h10000, 31'd0, 32'd1);          // zero page size
    send_item(arfl_pkg::ACT_FREE, 48'h10000, 31'd4096, 32'd4);
    send_item(arfl_pkg::ACT_ALLOC, '0, 31'd4096, 32'd1);
    send_item(arfl_pkg::ACT_AT, 48'h12001, 31'd4096, 32'd1);         // misaligned
    send_item(arfl_pkg::ACT_ALLOC, '0, 31'd4096, 32'd0);             // zero count
    send_item(arfl_pkg::ACT_FREE, 48'h20000, 31'd4096, 32'd0);
    send_item(arfl_pkg::ACT_FREE, 48'hFFFF_FFFF_F000, 31'd4096, 32'd1); // reaches last byte
    send_item(arfl_pkg::ACT_FREE, 48'hFFFF_FFFF_E000, 31'd4096, 32'd1);
    send_item(arfl_pkg::ACT_AT, 48'hFFFF_FFFF_E000, 31'd4096, 32'd1);
    send_item(ACT_BAD, 48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(arfl_pkg::ACT_FREE, '0, 31'h4000_0000, 32'hFFFF_FFFF);
    send_item(arfl_pkg::ACT_ALLOC, '0, 31'h4000_0000, 32'd1);
    send_item(arfl_pkg::ACT_FREE, 48'h11000, 31'd4096, 32'd1);       // inside a free region
    // fill the table with separated regions, then overflow it
    for (int k = 0; k < MAX_REGIONS; k++)
      send_item(arfl_pkg::ACT_FREE, 48'h200000 + 48'(k) * 48'h4000, 31'd4096, 32'd2);
    send_item(arfl_pkg::ACT_AT, 48'h201000, 31'd1024, 32'd1);        // split in a full table
    send_item(arfl_pkg::ACT_ALLOC, '0, 31'd8192, 32'd1);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) hold_req = 1;
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1;
      send_random();
    end
    in_valid_i <= 0;
    wait (pending == 0);
    repeat (2000) @(posedge clk_i);
    $display("Sent %0d requests: directed edge cases plus random alloc, alloc-at and free",
             items_sent);
    $display("over a merging pool, with idling, a long output hold-off and a full table.");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold-off, quiet at the end
  initial begin
    int left;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        left = 300;
      end
      if (left > 0) begin
        left--;
        out_stall_i <= 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        left = $urandom_range(0, 5);
        out_stall_i <= 1;
      end else begin
        out_stall_i <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

@@ sim.f @@
hdl/arfl_pkg.sv
hdl/arfl_ram.sv
hdl/arfl_mod_unit.sv
hdl/aligned_region_free_list_core.sv
verif/region_table_checker.sv
verif/aligned_region_free_list_core_test.sv
